/* hw/rtl/qm_pkg.sv */
// ----------------------------------------------------------------------------
// qm_pkg
// Shared widths, payload words and lane constants for the quaternion product.
// ----------------------------------------------------------------------------
package qm_pkg;

	// Component format: signed Q2.14 in 16 bits.
	localparam int COMP_WIDTH = 16;
	localparam int FRAC_BITS  = 14;

	// Product, exact four-term sum and rounded sum widths.
	localparam int PROD_WIDTH = 2 * COMP_WIDTH;
	localparam int SUM_WIDTH  = PROD_WIDTH + 2;
	localparam int RND_WIDTH  = SUM_WIDTH - FRAC_BITS;

	// One lane per output component, four products per lane.
	localparam int NUM_LANES = 4;
	localparam int NUM_TERMS = 4;

	typedef logic signed [COMP_WIDTH-1:0] comp_t;
	typedef logic signed [PROD_WIDTH-1:0] prod_t;
	typedef logic signed [RND_WIDTH-1:0]  rnd_t;
	typedef logic [NUM_TERMS-1:0]         neg_mask_t;

	// Input word: left and right quaternions in w,x,y,z order.
	typedef struct packed {
		comp_t a_w;
		comp_t a_x;
		comp_t a_y;
		comp_t a_z;
		comp_t b_w;
		comp_t b_x;
		comp_t b_y;
		comp_t b_z;
	} in_word_t;

	// Output word: rounded, saturated product and the clip flag.
	typedef struct packed {
		comp_t prod_w;
		comp_t prod_x;
		comp_t prod_y;
		comp_t prod_z;
		logic  saturated;
	} out_word_t;

	// Pipeline enables that the top level hands to every lane.
	typedef struct packed {
		logic en_s1;
		logic en_s2;
	} lane_ctl_t;

	// Lane L, term T multiplies a[T] by b[L ^ T]. Bit T of the mask marks a
	// term that is subtracted. Lane order is w, x, y, z.
	localparam neg_mask_t LANE_NEG [NUM_LANES] = '{
		4'b1110,
		4'b1000,
		4'b0010,
		4'b0100
	};

endpackage

/* hw/rtl/qm_lane.sv */
// ----------------------------------------------------------------------------
// qm_lane
// One product component: four signed multiplies, then a signed sum with the
// rounding half added and the fraction bits dropped.
// ----------------------------------------------------------------------------
module qm_lane (
	input  logic              clk,
	input  qm_pkg::lane_ctl_t ctl,
	input  qm_pkg::comp_t     a_op [qm_pkg::NUM_TERMS],
	input  qm_pkg::comp_t     b_op [qm_pkg::NUM_TERMS],
	input  qm_pkg::neg_mask_t neg,
	output qm_pkg::rnd_t      sum_s2
);
	import qm_pkg::*;

	localparam logic signed [SUM_WIDTH-1:0] HALF = SUM_WIDTH'(64'sd1 <<< (FRAC_BITS - 1));

	prod_t                   prod_s1 [NUM_TERMS];
	logic signed [SUM_WIDTH-1:0] acc;

	// Stage 1: the four products, one multiplier each.
	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			for (int t = 0; t < NUM_TERMS; t++) begin
				prod_s1[t] <= prod_t'(a_op[t]) * prod_t'(b_op[t]);
			end
		end
	end

	// Exact signed sum plus the rounding half; halves round up.
	always_comb begin
		acc = HALF;
		for (int t = 0; t < NUM_TERMS; t++) begin
			if (neg[t]) begin
				acc = acc - SUM_WIDTH'(prod_s1[t]);
			end else begin
				acc = acc + SUM_WIDTH'(prod_s1[t]);
			end
		end
	end

	// Stage 2: floor shift by the fraction bits.
	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			sum_s2 <= acc[SUM_WIDTH-1:FRAC_BITS];
		end
	end

endmodule

/* hw/rtl/qm_merge.sv */
// ----------------------------------------------------------------------------
// qm_merge
// Saturates the four lane sums to the component range, gathers the clip
// flag and holds the finished output word.
// ----------------------------------------------------------------------------
module qm_merge (
	input  logic              clk,
	input  logic              en,
	input  qm_pkg::rnd_t      sum_s2 [qm_pkg::NUM_LANES],
	output qm_pkg::out_word_t word_q
);
	import qm_pkg::*;

	localparam comp_t COMP_MAX = comp_t'({1'b0, {(COMP_WIDTH-1){1'b1}}});
	localparam comp_t COMP_MIN = comp_t'({1'b1, {(COMP_WIDTH-1){1'b0}}});

	comp_t comp [NUM_LANES];
	logic  clip [NUM_LANES];

	// A sum fits when every bit from the component sign up agrees.
	always_comb begin
		for (int l = 0; l < NUM_LANES; l++) begin
			clip[l] = !((&sum_s2[l][RND_WIDTH-1:COMP_WIDTH-1]) ||
				(~|sum_s2[l][RND_WIDTH-1:COMP_WIDTH-1]));
			if (!clip[l]) begin
				comp[l] = sum_s2[l][COMP_WIDTH-1:0];
			end else if (sum_s2[l][RND_WIDTH-1]) begin
				comp[l] = COMP_MIN;
			end else begin
				comp[l] = COMP_MAX;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (en) begin
			word_q.prod_w    <= comp[0];
			word_q.prod_x    <= comp[1];
			word_q.prod_y    <= comp[2];
			word_q.prod_z    <= comp[3];
			word_q.saturated <= clip[0] | clip[1] | clip[2] | clip[3];
		end
	end

endmodule

/* hw/rtl/quaternion_multiply.sv */
// ----------------------------------------------------------------------------
// quaternion_multiply
// Hamilton product a*b of two Q2.14 quaternions, rounded and saturated.
//
//   channel | direction | handshake           | word
//   --------+-----------+---------------------+---------------------
//   req     | in        | req_valid/req_stall | qm_pkg::in_word_t
//   rsp     | out       | rsp_valid/rsp_stall | qm_pkg::out_word_t
//
// One word in and one word out per cycle while rsp_stall is low.
// Stage 1 holds the sixteen products, stage 2 the four rounded sums, and
// the output register the saturated result.
// Reset clears only the stage valid bits; no flush pass is needed.
// A stall on rsp backs up stage by stage; req_stall rises only once all
// three stages hold a word.
// ----------------------------------------------------------------------------
module quaternion_multiply (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  qm_pkg::in_word_t  req_word,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output qm_pkg::out_word_t rsp_word
);
	import qm_pkg::*;

	localparam comp_t COMP_MAX = comp_t'({1'b0, {(COMP_WIDTH-1){1'b1}}});
	localparam comp_t COMP_MIN = comp_t'({1'b1, {(COMP_WIDTH-1){1'b0}}});

	logic      v_s1, v_s2, v_q;
	logic      rdy_s1, rdy_s2, rdy_q;
	logic      en_q;
	lane_ctl_t ctl;
	comp_t     a_vec [NUM_TERMS];
	comp_t     b_vec [NUM_TERMS];
	rnd_t      sum_s2 [NUM_LANES];

	// A stage can take a word when it is empty or its word moves on.
	assign rdy_q     = !v_q || !rsp_stall;
	assign rdy_s2    = !v_s2 || rdy_q;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign ctl.en_s1 = req_valid && rdy_s1;
	assign ctl.en_s2 = v_s1 && rdy_s2;
	assign en_q      = v_s2 && rdy_q;
	assign req_stall = !rdy_s1;
	assign rsp_valid = v_q;

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_q  <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= req_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_q) begin
				v_q <= v_s2;
			end
		end
	end

	// Component vectors in w,x,y,z order.
	assign a_vec[0] = req_word.a_w;
	assign a_vec[1] = req_word.a_x;
	assign a_vec[2] = req_word.a_y;
	assign a_vec[3] = req_word.a_z;
	assign b_vec[0] = req_word.b_w;
	assign b_vec[1] = req_word.b_x;
	assign b_vec[2] = req_word.b_y;
	assign b_vec[3] = req_word.b_z;

	// One lane per product component; lane L pairs a[T] with b[L ^ T].
	for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
		comp_t b_sel [NUM_TERMS];

		for (genvar t = 0; t < NUM_TERMS; t++) begin : g_term
			assign b_sel[t] = b_vec[l ^ t];
		end

		qm_lane u_lane (
			.clk    (clk),
			.ctl    (ctl),
			.a_op   (a_vec),
			.b_op   (b_sel),
			.neg    (LANE_NEG[l]),
			.sum_s2 (sum_s2[l])
		);
	end

	// Saturation, flag merge and output register.
	qm_merge u_merge (
		.clk    (clk),
		.en     (en_q),
		.sum_s2 (sum_s2),
		.word_q (rsp_word)
	);

	// The input stalls only when every stage is occupied.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (v_s1 && v_s2 && v_q))
		else $error("input stalled with an empty stage");

	// A word leaving stage 2 shows up at the output next cycle.
	a_s2_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && rdy_q) |=> rsp_valid)
		else $error("stage 2 word did not reach the output");

	// A clip flag means some component sits at a range limit.
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_word.saturated) |->
			(rsp_word.prod_w == COMP_MAX || rsp_word.prod_w == COMP_MIN ||
			rsp_word.prod_x == COMP_MAX || rsp_word.prod_x == COMP_MIN ||
			rsp_word.prod_y == COMP_MAX || rsp_word.prod_y == COMP_MIN ||
			rsp_word.prod_z == COMP_MAX || rsp_word.prod_z == COMP_MIN))
		else $error("saturated flag without a clipped component");

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the quaternion product block. Every accepted
// request word is run through a behavioral Hamilton product in the bench, and
// each response word is compared with the oldest prediction. Stimulus covers
// corner operands, rounding halves and a long random run, with random gaps
// on the request side and random stalls on the response side.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import qm_pkg::*;

	localparam int  GAP_MAX     = 10;
	localparam int  RANDOM_RUN  = 1420;
	localparam int  CYCLE_LIMIT = 400000;
	localparam int  REPORT_MAX  = 10;
	localparam int  DRAIN_WAIT  = 10;

	// Handy Q2.14 values.
	localparam comp_t C_MAX  = 16'sh7fff;
	localparam comp_t C_MIN  = 16'sh8000;
	localparam comp_t C_ONE  = 16'sh4000;
	localparam comp_t C_MONE = 16'shc000;
	localparam comp_t C_HALF = 16'sh2000;
	localparam comp_t C_ZERO = 16'sh0000;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	in_word_t  req_word = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	out_word_t rsp_word;

	// Predicted products, oldest first.
	out_word_t product_q[$];

	bit send_idle = 1'b1;
	bit recv_idle = 1'b1;
	int err_count = 0;
	int words_sent = 0;
	int words_checked = 0;
	int clip_count = 0;
	int cycle_count = 0;
	int hold_left = 0;

	quaternion_multiply dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_word  (req_word),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_word  (rsp_word)
	);

	always #1 clk = ~clk;

	// Round a four-term sum to nearest (halves up) and clip to the component range.
	function automatic comp_t round_clip(input longint acc, inout bit clip);
		longint r;
		longint top;
		longint bottom;
		top = (longint'(1) <<< (COMP_WIDTH - 1)) - 1;
		bottom = -top - 1;
		r = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		if (r > top) begin
			r = top;
			clip = 1'b1;
		end else if (r < bottom) begin
			r = bottom;
			clip = 1'b1;
		end
		return comp_t'(r);
	endfunction

	// Hamilton product a*b of one request word.
	function automatic out_word_t hamilton_product(input in_word_t w);
		longint aw, ax, ay, az, bw, bx, by, bz;
		bit clip;
		out_word_t p;
		aw = w.a_w; ax = w.a_x; ay = w.a_y; az = w.a_z;
		bw = w.b_w; bx = w.b_x; by = w.b_y; bz = w.b_z;
		clip = 1'b0;
		p.prod_w = round_clip(aw * bw - ax * bx - ay * by - az * bz, clip);
		p.prod_x = round_clip(aw * bx + ax * bw + ay * bz - az * by, clip);
		p.prod_y = round_clip(aw * by - ax * bz + ay * bw + az * bx, clip);
		p.prod_z = round_clip(aw * bz + ax * by - ay * bx + az * bw, clip);
		p.saturated = clip;
		return p;
	endfunction

	// Draw one operand: full range, within plus or minus one, or a corner value.
	function automatic comp_t pick_operand();
		int mode;
		mode = $urandom_range(0, 99);
		if (mode < 55)
			return comp_t'($urandom);
		else if (mode < 85)
			return comp_t'($urandom_range(0, 32768) - 16384);
		case ($urandom_range(0, 6))
			0: return C_MAX;
			1: return C_MIN;
			2: return C_ONE;
			3: return C_MONE;
			4: return 16'sh0001;
			5: return 16'shffff;
			default: return C_ZERO;
		endcase
	endfunction

	function automatic in_word_t make_word(input comp_t aw, ax, ay, az, bw, bx, by, bz);
		in_word_t w;
		w.a_w = aw; w.a_x = ax; w.a_y = ay; w.a_z = az;
		w.b_w = bw; w.b_x = bx; w.b_y = by; w.b_z = bz;
		return w;
	endfunction

	// Send one word, after a random gap while send_idle is set, and record its product once accepted.
	task automatic send_word(input in_word_t w);
		int gap;
		gap = send_idle ? $urandom_range(0, GAP_MAX) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_word <= w;
		do
			@(posedge clk);
		while (req_stall !== 1'b0);
		product_q.push_back(hamilton_product(w));
		words_sent++;
	endtask

	task automatic lower_valid();
		req_valid <= 1'b0;
	endtask

	// Hold the request side until every predicted product has come back.
	task automatic wait_drained();
		while (product_q.size() != 0)
			@(posedge clk);
	endtask

	// Zeros, full-scale operands of both signs, identity and basis products.
	task automatic test_corner_operands();
		send_word(make_word(C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO));
		send_word(make_word(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX));
		send_word(make_word(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN));
		send_word(make_word(C_MAX, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, C_MAX));
		send_word(make_word(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MIN, C_MIN, C_MIN));
		send_word(make_word(C_ONE, C_ZERO, C_ZERO, C_ZERO, C_MAX, C_MIN, 16'sh1234, C_MONE));
		send_word(make_word(C_MAX, C_MIN, 16'sh1234, C_MONE, C_ONE, C_ZERO, C_ZERO, C_ZERO));
		// i*j, j*k, k*i and j*i give the basis signs.
		send_word(make_word(C_ZERO, C_ONE, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ONE, C_ZERO));
		send_word(make_word(C_ZERO, C_ZERO, C_ONE, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ONE));
		send_word(make_word(C_ZERO, C_ZERO, C_ZERO, C_ONE, C_ZERO, C_ONE, C_ZERO, C_ZERO));
		send_word(make_word(C_ZERO, C_ZERO, C_ONE, C_ZERO, C_ZERO, C_ONE, C_ZERO, C_ZERO));
		send_word(make_word(C_ZERO, C_ONE, C_ONE, C_ONE, C_ZERO, C_ONE, C_ONE, C_ONE));
		// Alternating bit patterns toggle every input bit.
		send_word(make_word(16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa,
			16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555));
		send_word(make_word(16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555,
			16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa));
		lower_valid();
	endtask

	// Sums that land exactly on a half, and just either side of one.
	task automatic test_rounding_halves();
		send_word(make_word(16'sh0001, C_ZERO, C_ZERO, C_ZERO, C_HALF, C_ZERO, C_ZERO, C_ZERO));
		send_word(make_word(16'shffff, C_ZERO, C_ZERO, C_ZERO, C_HALF, C_ZERO, C_ZERO, C_ZERO));
		send_word(make_word(16'sh0003, C_ZERO, C_ZERO, C_ZERO, C_HALF, C_ZERO, C_ZERO, C_ZERO));
		send_word(make_word(16'shfffd, C_ZERO, C_ZERO, C_ZERO, C_HALF, C_ZERO, C_ZERO, C_ZERO));
		send_word(make_word(16'sh0001, C_ZERO, C_ZERO, C_ZERO, 16'sh1fff, C_ZERO, C_ZERO, C_ZERO));
		send_word(make_word(16'shffff, C_ZERO, C_ZERO, C_ZERO, 16'sh2001, C_ZERO, C_ZERO, C_ZERO));
		// Half built from two terms: aw*bx plus ax*bw in the x lane.
		send_word(make_word(16'sh0001, 16'sh0001, C_ZERO, C_ZERO,
			16'sh1000, 16'sh1000, C_ZERO, C_ZERO));
		// Saturation: the x component lands at about four times full scale.
		send_word(make_word(C_MAX, C_MAX, C_ZERO, C_ZERO, C_MAX, C_MAX, C_ZERO, C_ZERO));
		lower_valid();
	endtask

	// Long random run; idling on each side changes in stretches.
	task automatic test_random_products();
		for (int n = 0; n < RANDOM_RUN; n++) begin
			if (n % 100 == 0) begin
				send_idle = ($urandom_range(0, 3) != 0);
				recv_idle = ($urandom_range(0, 3) != 0);
			end
			send_word(make_word(pick_operand(), pick_operand(), pick_operand(),
				pick_operand(), pick_operand(), pick_operand(), pick_operand(),
				pick_operand()));
			if (n % 350 == 349) begin
				lower_valid();
				wait_drained();
			end
		end
		lower_valid();
		send_idle = 1'b1;
		recv_idle = 1'b1;
	endtask

	// Back-to-back burst against a stalling receiver, then a full drain.
	task automatic test_pause_until_drained();
		send_idle = 1'b0;
		for (int n = 0; n < 20; n++)
			send_word(make_word(pick_operand(), pick_operand(), pick_operand(),
				pick_operand(), pick_operand(), pick_operand(), pick_operand(),
				pick_operand()));
		lower_valid();
		wait_drained();
		send_idle = 1'b1;
	endtask

	// Response side: check each accepted word, then stall for a random count while recv_idle is set.
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			words_checked++;
			if (product_q.size() == 0) begin
				err_count++;
				if (err_count <= REPORT_MAX)
					$display("ERROR: unexpected response word %h", rsp_word);
			end else begin
				want = product_q.pop_front();
				if (want.saturated)
					clip_count++;
				if (rsp_word.prod_w !== want.prod_w || rsp_word.prod_x !== want.prod_x ||
						rsp_word.prod_y !== want.prod_y || rsp_word.prod_z !== want.prod_z ||
						rsp_word.saturated !== want.saturated) begin
					err_count++;
					if (err_count <= REPORT_MAX)
						$display("ERROR: product w/x/y/z/sat expected %h %h %h %h %b, got %h %h %h %h %b",
							want.prod_w, want.prod_x, want.prod_y, want.prod_z, want.saturated,
							rsp_word.prod_w, rsp_word.prod_x, rsp_word.prod_y, rsp_word.prod_z,
							rsp_word.saturated);
				end
			end
			hold_left = recv_idle ? $urandom_range(0, GAP_MAX) : 0;
		end
		if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left--;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d products pending",
				cycle_count, product_q.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_operands();
		test_rounding_halves();
		test_pause_until_drained();
		test_random_products();
		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("Sent %0d words, checked %0d products, %0d of them clipped, %0d mismatches.",
			words_sent, words_checked, clip_count, err_count);
		if (err_count == 0 && product_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
